// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the scroll camera tile walker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_CLK_MSG(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_CLK_MSG(lbl, clk, rst_n, prop, msg)
`endif

`endif

// ----- rtl/scw_pkg.sv -----
// Shared constants for the scroll camera tile walker
package scw_pkg;

  localparam int COORD_BITS_DEF   = 16;
  localparam int MAP_DIM_BITS_DEF = 10;

  localparam int VIEW_BITS   = 12;
  localparam int TILE_BITS   = 8;
  localparam int MAPREG_BITS = 11;
  localparam int BOUND_BITS  = 16;
  localparam int ARG_BITS    = 17;
  localparam int INDEX_BITS  = 20;
  localparam int SCREEN_BITS = 13;
  localparam int CMD_BITS    = 2;

  localparam int IN_TDATA_BITS  = 40;
  localparam int OUT_TDATA_BITS = 48;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CMD_BITS-1:0] CMD_PAN  = 2'd0;
  localparam logic [CMD_BITS-1:0] CMD_JUMP = 2'd1;
  localparam logic [CMD_BITS-1:0] CMD_NEXT = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_VIEW_W  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_VIEW_H  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_TILE_W  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_TILE_H  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAP_COL = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_MAP_ROW = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOUND_W = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOUND_H = 3'd7;

  localparam logic [VIEW_BITS-1:0]   RST_VIEW_W  = 12'd320;
  localparam logic [VIEW_BITS-1:0]   RST_VIEW_H  = 12'd240;
  localparam logic [TILE_BITS-1:0]   RST_TILE_W  = 8'd16;
  localparam logic [TILE_BITS-1:0]   RST_TILE_H  = 8'd16;
  localparam logic [MAPREG_BITS-1:0] RST_MAP_COL = 11'd64;
  localparam logic [MAPREG_BITS-1:0] RST_MAP_ROW = 11'd64;

endpackage

// ----- rtl/scw_div.sv -----
// Restoring divider, one quotient bit per cycle
module scw_div #(
  parameter int DIVIDEND_BITS = scw_pkg::COORD_BITS_DEF + 1,
  parameter int DIVISOR_BITS  = scw_pkg::TILE_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [DIVISOR_BITS-1:0]  divisor,
  output logic                     done,
  output logic [DIVIDEND_BITS-1:0] quotient
);

  localparam int CNTW = $clog2(DIVIDEND_BITS + 1);

  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [CNTW-1:0]          cnt_r, cnt_nxt;
  logic [DIVISOR_BITS-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_BITS-1:0]  dvs_r, dvs_nxt;
  logic [DIVIDEND_BITS-1:0] quo_r, quo_nxt;

  logic [DIVISOR_BITS:0]    trial;
  logic [DIVISOR_BITS:0]    diff;
  logic                     ge;

  assign trial = {rem_r, quo_r[DIVIDEND_BITS-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNTW'(DIVIDEND_BITS);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
      quo_nxt = {quo_r[DIVIDEND_BITS-2:0], ge};
      cnt_nxt = cnt_r - CNTW'(1);
      if (cnt_r == CNTW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/scroll_camera_tile_walker.sv -----
// Scroll camera tile walker: top level, command sequencer and camera/walk state
//
// Input stream: one command per transfer; in_tuser carries the command (pan, jump,
// next tile), in_tdata the x and y arguments. Output stream: exactly one result per
// command; out_tuser flags a visible tile, out_tlast marks the last tile of a walk
// (or an empty walk). Configuration registers are written through cfg_wr_en /
// cfg_index / cfg_wdata; the user must do so only while the block is idle, as the
// block itself does not enforce it. Pan, jump and unknown commands go straight to
// the output stage; a next tile within a walk makes three passes through the shared
// multiplier, then the result stage. A next tile that starts a walk first runs four
// divisions through the shared bit-serial divider.
// The result sits in an output register; a new command is taken while it waits.
// If the receiver stalls, the next result is held in the sequencer until the
// output register frees, and no further command is taken meanwhile.
// Reset (synchronous, rst_n low) restores the register defaults, puts the camera
// at zero, ends any walk and empties the output register.
`include "assert_macros.svh"

module scroll_camera_tile_walker #(
  parameter int COORD_BITS   = scw_pkg::COORD_BITS_DEF,
  parameter int MAP_DIM_BITS = scw_pkg::MAP_DIM_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // tdata: arg_x[16:0], arg_y[33:17], zero pad [39:34]
  input  logic [scw_pkg::IN_TDATA_BITS-1:0]    in_tdata,
  // tuser: cmd[1:0]
  input  logic [scw_pkg::CMD_BITS-1:0]         in_tuser,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // tdata: pan_blocked[1:0], map_index[21:2], screen_x[34:22], screen_y[47:35]
  output logic [scw_pkg::OUT_TDATA_BITS-1:0]   out_tdata,
  // tuser: tile_valid
  output logic                                 out_tuser,
  output logic                                 out_tlast,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  input  logic                                 cfg_wr_en,
  input  logic [scw_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [scw_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

  localparam int CB  = COORD_BITS;
  localparam int MDB = MAP_DIM_BITS;
  localparam int AB  = scw_pkg::ARG_BITS;
  localparam int PW  = (CB > AB ? CB : AB) + 2;
  localparam int DW  = (CB > scw_pkg::VIEW_BITS ? CB : scw_pkg::VIEW_BITS) + 1;
  localparam int KW0 = (DW > MDB + 2) ? DW : MDB + 2;
  localparam int KW  = (KW0 > 12) ? KW0 : 12;
  localparam int MW  = MDB + scw_pkg::MAPREG_BITS;
  localparam int EW0 = (MW > scw_pkg::INDEX_BITS) ? MW : scw_pkg::INDEX_BITS;
  localparam int EW  = ((EW0 > CB) ? EW0 : CB) + 1;
  localparam int TB  = scw_pkg::TILE_BITS;
  localparam int SB  = scw_pkg::SCREEN_BITS;
  localparam int IB  = scw_pkg::INDEX_BITS;

  localparam logic [KW-1:0] DIM_LIM = KW'(1) << MDB;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_DIV_GO   = 4'd1;
  localparam logic [3:0] ST_DIV_WAIT = 4'd2;
  localparam logic [3:0] ST_CHK      = 4'd3;
  localparam logic [3:0] ST_MUL_IDX  = 4'd4;
  localparam logic [3:0] ST_MUL_X    = 4'd5;
  localparam logic [3:0] ST_MUL_Y    = 4'd6;
  localparam logic [3:0] ST_FIN      = 4'd7;
  localparam logic [3:0] ST_EMIT     = 4'd8;

  // configuration
  logic [scw_pkg::VIEW_BITS-1:0]   view_w_r, view_h_r;
  logic [TB-1:0]                   tile_w_r, tile_h_r;
  logic [scw_pkg::MAPREG_BITS-1:0] map_cols_r, map_rows_r;
  logic [scw_pkg::BOUND_BITS-1:0]  bound_w_r, bound_h_r;

  // camera and walk
  logic [CB-1:0]  cam_x_r, cam_x_nxt, cam_y_r, cam_y_nxt;
  logic           walk_active_r, walk_active_nxt;
  logic [MDB-1:0] cur_row_r, cur_row_nxt, cur_col_r, cur_col_nxt;
  logic [MDB-1:0] first_col_r, first_col_nxt, last_col_r, last_col_nxt;
  logic [MDB-1:0] last_row_r, last_row_nxt;

  // sequencer
  logic [3:0]     state_r, state_nxt;
  logic [1:0]     div_sel_r, div_sel_nxt;
  logic [DW-1:0]  r0_r, r0_nxt, r1_r, r1_nxt, c0_r, c0_nxt, c1_r, c1_nxt;
  logic [MW-1:0]  mul_r, mul_nxt;

  // result staging and output register
  logic [1:0]     res_blk_r, res_blk_nxt;
  logic           res_valid_r, res_valid_nxt;
  logic [IB-1:0]  res_idx_r, res_idx_nxt;
  logic [SB-1:0]  res_sx_r, res_sx_nxt, res_sy_r, res_sy_nxt;
  logic           res_last_r, res_last_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [scw_pkg::OUT_TDATA_BITS-1:0] out_data_r, out_data_nxt;
  logic           out_user_r, out_user_nxt, out_last_r, out_last_nxt;

  logic           in_acc;
  logic [AB-1:0]  arg_x, arg_y;
  logic [TB-1:0]  tw_eff, th_eff;

  // pan / jump arithmetic
  logic signed [PW-1:0] px, py;
  logic [PW-1:0]        ax_ext, ay_ext, pxv, pyv;
  logic                 x_ok, y_ok;
  logic [CB-1:0]        jx, jy;

  // divider port
  logic           div_start, div_done;
  logic [DW-1:0]  div_dividend, div_quot;
  logic [TB-1:0]  div_divisor;

  // walk start and tile arithmetic
  logic [KW-1:0]  rows_k, cols_k, r0_k, c0_k, r1_k, c1_k, r1_c, c1_c;
  logic           walk_empty;
  logic [MDB-1:0] mul_a;
  logic [scw_pkg::MAPREG_BITS-1:0] mul_b;
  logic [EW-1:0]  idx_sum, sx_diff, sy_diff;
  logic           tile_fin;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign arg_x     = in_tdata[AB-1:0];
  assign arg_y     = in_tdata[2*AB-1:AB];
  assign tw_eff    = (tile_w_r == '0) ? TB'(1) : tile_w_r;
  assign th_eff    = (tile_h_r == '0) ? TB'(1) : tile_h_r;

  assign ax_ext = {{(PW-AB){arg_x[AB-1]}}, arg_x};
  assign ay_ext = {{(PW-AB){arg_y[AB-1]}}, arg_y};
  assign px     = $signed({{(PW-CB){1'b0}}, cam_x_r}) + $signed(ax_ext);
  assign py     = $signed({{(PW-CB){1'b0}}, cam_y_r}) + $signed(ay_ext);
  assign pxv    = $unsigned(px) + PW'(view_w_r);
  assign pyv    = $unsigned(py) + PW'(view_h_r);
  assign x_ok   = !px[PW-1] && (pxv < PW'(bound_w_r)) && (px[PW-2:CB] == '0);
  assign y_ok   = !py[PW-1] && (pyv < PW'(bound_h_r)) && (py[PW-2:CB] == '0);
  assign jx     = ax_ext[PW-1] ? '0 : ((ax_ext[PW-2:CB] != '0) ? '1 : ax_ext[CB-1:0]);
  assign jy     = ay_ext[PW-1] ? '0 : ((ay_ext[PW-2:CB] != '0) ? '1 : ay_ext[CB-1:0]);

  always_comb begin
    case (div_sel_r)
      2'd0: begin
        div_dividend = DW'(cam_y_r);
        div_divisor  = th_eff;
      end
      2'd1: begin
        div_dividend = DW'(cam_y_r) + DW'(view_h_r);
        div_divisor  = th_eff;
      end
      2'd2: begin
        div_dividend = DW'(cam_x_r);
        div_divisor  = tw_eff;
      end
      default: begin
        div_dividend = DW'(cam_x_r) + DW'(view_w_r);
        div_divisor  = tw_eff;
      end
    endcase
  end

  assign div_start = (state_r == ST_DIV_GO);

  scw_div #(
    .DIVIDEND_BITS (DW),
    .DIVISOR_BITS  (TB)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // walk bounds, clipped to the map
  assign rows_k     = (KW'(map_rows_r) > DIM_LIM) ? DIM_LIM : KW'(map_rows_r);
  assign cols_k     = (KW'(map_cols_r) > DIM_LIM) ? DIM_LIM : KW'(map_cols_r);
  assign r0_k       = KW'(r0_r);
  assign c0_k       = KW'(c0_r);
  assign r1_k       = KW'(r1_r);
  assign c1_k       = KW'(c1_r);
  assign r1_c       = (r1_k > rows_k - KW'(1)) ? rows_k - KW'(1) : r1_k;
  assign c1_c       = (c1_k > cols_k - KW'(1)) ? cols_k - KW'(1) : c1_k;
  assign walk_empty = (rows_k == '0) || (cols_k == '0) || (r0_k >= rows_k) ||
                      (c0_k >= cols_k);

  // shared multiplier operands
  always_comb begin
    case (state_r)
      ST_MUL_X: begin
        mul_a = cur_col_r;
        mul_b = scw_pkg::MAPREG_BITS'(tw_eff);
      end
      ST_MUL_Y: begin
        mul_a = cur_row_r;
        mul_b = scw_pkg::MAPREG_BITS'(th_eff);
      end
      default: begin
        mul_a = cur_row_r;
        mul_b = map_cols_r;
      end
    endcase
  end

  assign mul_nxt  = MW'(mul_a) * MW'(mul_b);
  assign idx_sum  = EW'(mul_r) + EW'(cur_col_r);
  assign sx_diff  = EW'(mul_r) - EW'(cam_x_r);
  assign sy_diff  = EW'(mul_r) - EW'(cam_y_r);
  assign tile_fin = (cur_row_r >= last_row_r) && (cur_col_r >= last_col_r);

  always_comb begin
    state_nxt       = state_r;
    div_sel_nxt     = div_sel_r;
    cam_x_nxt       = cam_x_r;
    cam_y_nxt       = cam_y_r;
    walk_active_nxt = walk_active_r;
    cur_row_nxt     = cur_row_r;
    cur_col_nxt     = cur_col_r;
    first_col_nxt   = first_col_r;
    last_col_nxt    = last_col_r;
    last_row_nxt    = last_row_r;
    r0_nxt          = r0_r;
    r1_nxt          = r1_r;
    c0_nxt          = c0_r;
    c1_nxt          = c1_r;
    res_blk_nxt     = res_blk_r;
    res_valid_nxt   = res_valid_r;
    res_idx_nxt     = res_idx_r;
    res_sx_nxt      = res_sx_r;
    res_sy_nxt      = res_sy_r;
    res_last_nxt    = res_last_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_data_nxt    = out_data_r;
    out_user_nxt    = out_user_r;
    out_last_nxt    = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          res_blk_nxt   = 2'b00;
          res_valid_nxt = 1'b0;
          res_idx_nxt   = '0;
          res_sx_nxt    = '0;
          res_sy_nxt    = '0;
          res_last_nxt  = 1'b0;
          state_nxt     = ST_EMIT;
          case (in_tuser)
            scw_pkg::CMD_PAN: begin
              if (x_ok) cam_x_nxt = px[CB-1:0];
              if (y_ok) cam_y_nxt = py[CB-1:0];
              res_blk_nxt     = {!y_ok, !x_ok};
              walk_active_nxt = 1'b0;
            end
            scw_pkg::CMD_JUMP: begin
              cam_x_nxt       = jx;
              cam_y_nxt       = jy;
              walk_active_nxt = 1'b0;
            end
            scw_pkg::CMD_NEXT: begin
              if (walk_active_r) begin
                state_nxt = ST_MUL_IDX;
              end else begin
                div_sel_nxt = 2'd0;
                state_nxt   = ST_DIV_GO;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV_GO: begin
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          case (div_sel_r)
            2'd0:    r0_nxt = div_quot;
            2'd1:    r1_nxt = div_quot;
            2'd2:    c0_nxt = div_quot;
            default: c1_nxt = div_quot;
          endcase
          div_sel_nxt = div_sel_r + 2'd1;
          state_nxt   = (div_sel_r == 2'd3) ? ST_CHK : ST_DIV_GO;
        end
      end
      ST_CHK: begin
        if (walk_empty) begin
          res_last_nxt = 1'b1;
          state_nxt    = ST_EMIT;
        end else begin
          cur_row_nxt     = r0_k[MDB-1:0];
          cur_col_nxt     = c0_k[MDB-1:0];
          first_col_nxt   = c0_k[MDB-1:0];
          last_col_nxt    = c1_c[MDB-1:0];
          last_row_nxt    = r1_c[MDB-1:0];
          walk_active_nxt = 1'b1;
          state_nxt       = ST_MUL_IDX;
        end
      end
      ST_MUL_IDX: begin
        state_nxt = ST_MUL_X;
      end
      ST_MUL_X: begin
        res_idx_nxt = idx_sum[IB-1:0];
        state_nxt   = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        res_sx_nxt = sx_diff[SB-1:0];
        state_nxt  = ST_FIN;
      end
      ST_FIN: begin
        res_sy_nxt    = sy_diff[SB-1:0];
        res_valid_nxt = 1'b1;
        res_last_nxt  = tile_fin;
        if (tile_fin) begin
          walk_active_nxt = 1'b0;
        end else if (cur_col_r >= last_col_r) begin
          cur_col_nxt = first_col_r;
          cur_row_nxt = cur_row_r + MDB'(1);
        end else begin
          cur_col_nxt = cur_col_r + MDB'(1);
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {res_sy_r, res_sx_r, res_idx_r, res_blk_r};
          out_user_nxt  = res_valid_r;
          out_last_nxt  = res_last_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_w_r   <= scw_pkg::RST_VIEW_W;
      view_h_r   <= scw_pkg::RST_VIEW_H;
      tile_w_r   <= scw_pkg::RST_TILE_W;
      tile_h_r   <= scw_pkg::RST_TILE_H;
      map_cols_r <= scw_pkg::RST_MAP_COL;
      map_rows_r <= scw_pkg::RST_MAP_ROW;
      bound_w_r  <= '0;
      bound_h_r  <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        scw_pkg::REG_VIEW_W:  view_w_r   <= cfg_wdata[scw_pkg::VIEW_BITS-1:0];
        scw_pkg::REG_VIEW_H:  view_h_r   <= cfg_wdata[scw_pkg::VIEW_BITS-1:0];
        scw_pkg::REG_TILE_W:  tile_w_r   <= cfg_wdata[TB-1:0];
        scw_pkg::REG_TILE_H:  tile_h_r   <= cfg_wdata[TB-1:0];
        scw_pkg::REG_MAP_COL: map_cols_r <= cfg_wdata[scw_pkg::MAPREG_BITS-1:0];
        scw_pkg::REG_MAP_ROW: map_rows_r <= cfg_wdata[scw_pkg::MAPREG_BITS-1:0];
        scw_pkg::REG_BOUND_W: bound_w_r  <= cfg_wdata[scw_pkg::BOUND_BITS-1:0];
        scw_pkg::REG_BOUND_H: bound_h_r  <= cfg_wdata[scw_pkg::BOUND_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      div_sel_r     <= 2'd0;
      cam_x_r       <= '0;
      cam_y_r       <= '0;
      walk_active_r <= 1'b0;
      cur_row_r     <= '0;
      cur_col_r     <= '0;
      first_col_r   <= '0;
      last_col_r    <= '0;
      last_row_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      div_sel_r     <= div_sel_nxt;
      cam_x_r       <= cam_x_nxt;
      cam_y_r       <= cam_y_nxt;
      walk_active_r <= walk_active_nxt;
      cur_row_r     <= cur_row_nxt;
      cur_col_r     <= cur_col_nxt;
      first_col_r   <= first_col_nxt;
      last_col_r    <= last_col_nxt;
      last_row_r    <= last_row_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    r0_r        <= r0_nxt;
    r1_r        <= r1_nxt;
    c0_r        <= c0_nxt;
    c1_r        <= c1_nxt;
    mul_r       <= mul_nxt;
    res_blk_r   <= res_blk_nxt;
    res_valid_r <= res_valid_nxt;
    res_idx_r   <= res_idx_nxt;
    res_sx_r    <= res_sx_nxt;
    res_sy_r    <= res_sy_nxt;
    res_last_r  <= res_last_nxt;
    out_data_r  <= out_data_nxt;
    out_user_r  <= out_user_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  `ASSERT_CLK(a_row_in_walk, clk, rst_n, walk_active_r |-> (cur_row_r <= last_row_r))
  `ASSERT_CLK(a_col_in_walk, clk, rst_n, walk_active_r |-> ((cur_col_r >= first_col_r) && (cur_col_r <= last_col_r)))
  `ASSERT_CLK(a_busy_after_take, clk, rst_n, (in_tvalid && in_tready) |=> !in_tready)
  `ASSERT_CLK_MSG(a_div_done_wait, clk, rst_n, div_done |-> (state_r == ST_DIV_WAIT), "divider finished outside its wait state")

endmodule
